@@ hdl/uvs_pkg.sv @@
// shared constants, types and the cordic arctangent table of the uv sphere vertex unit
package uvs_pkg;

    localparam int SEG_DEFAULT    = 256;
    localparam int CORDIC_DEFAULT = 16;
    localparam int ATAN_ENTRIES   = 24;

    localparam int CNT_W     = 9;
    localparam int RAD_W     = 16;
    localparam int POS_W     = 17;
    localparam int NORM_W    = 16;
    localparam int TEX_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // cordic datapath widths, q2.30 values with headroom
    localparam int XY_W = 34;
    localparam int Z_W  = 33;

    localparam logic [30:0]           HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sh26DD3B6A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_SLICES = 2'd1,
        CFG_STACKS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
    } cordic_t;

    // truncated q30 arctangent of 2^-idx
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] a;
        case (idx)
            0:       a = 32'h3243F6A8;
            1:       a = 32'h1DAC6705;
            2:       a = 32'h0FADBAFC;
            3:       a = 32'h07F56EA6;
            4:       a = 32'h03FEAB76;
            5:       a = 32'h01FFD55B;
            6:       a = 32'h00FFFAAA;
            7:       a = 32'h007FFF55;
            8:       a = 32'h003FFFEA;
            9:       a = 32'h001FFFFD;
            10:      a = 32'h000FFFFF;
            11:      a = 32'h0007FFFF;
            12:      a = 32'h0003FFFF;
            13:      a = 32'h0001FFFF;
            14:      a = 32'h0000FFFF;
            15:      a = 32'h00007FFF;
            16:      a = 32'h00003FFF;
            17:      a = 32'h00001FFF;
            18:      a = 32'h00000FFF;
            19:      a = 32'h000007FF;
            20:      a = 32'h000003FF;
            21:      a = 32'h000001FF;
            22:      a = 32'h000000FF;
            23:      a = 32'h0000007F;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

@@ hdl/uvs_div_cell.sv @@
// one restoring division step, shifts one numerator bit in and one quotient bit out
module uvs_div_cell #(
    parameter int W = 16
) (
    input  logic                        clk,
    input  logic [uvs_pkg::CNT_W-1:0]   divisor,
    input  logic [uvs_pkg::CNT_W-1:0]   rem_in,
    input  logic [W-1:0]                bits_in,
    output logic [uvs_pkg::CNT_W-1:0]   rem_out,
    output logic [W-1:0]                bits_out
);
    import uvs_pkg::*;

    logic [CNT_W:0]   trial;
    logic             fits;
    logic [CNT_W-1:0] rem_next;
    logic [W-1:0]     bits_next;
    logic [CNT_W-1:0] rem_reg;
    logic [W-1:0]     bits_reg;

    always_comb
    begin
        trial     = {rem_in, bits_in[W-1]};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
        bits_next = {bits_in[W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
    end

    assign rem_out  = rem_reg;
    assign bits_out = bits_reg;
endmodule

@@ hdl/uvs_div_chain.sv @@
// row of division cells giving a rounded quotient, with an output delay for alignment
module uvs_div_chain #(
    parameter int STEPS = 16,
    parameter int PAD   = 0
) (
    input  logic                        clk,
    input  logic [uvs_pkg::CNT_W-1:0]   divisor,
    input  logic [uvs_pkg::CNT_W-1:0]   rem_in,
    input  logic [STEPS-1:0]            bits_in,
    output logic [STEPS-1:0]            quot
);
    import uvs_pkg::*;

    logic [CNT_W-1:0] rem_w  [STEPS+1];
    logic [STEPS-1:0] bits_w [STEPS+1];

    assign rem_w[0]  = rem_in;
    assign bits_w[0] = bits_in;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        uvs_div_cell #(.W(STEPS)) u_cell (
            .clk      (clk),
            .divisor  (divisor),
            .rem_in   (rem_w[i]),
            .bits_in  (bits_w[i]),
            .rem_out  (rem_w[i+1]),
            .bits_out (bits_w[i+1])
        );
    end

    if (PAD == 0)
    begin : g_nopad
        assign quot = bits_w[STEPS];
    end
    else
    begin : g_pad
        logic [STEPS-1:0] pad_reg [PAD];
        always_ff @(posedge clk)
        begin
            pad_reg[0] <= bits_w[STEPS];
            for (int k = 1; k < PAD; k++)
            begin
                pad_reg[k] <= pad_reg[k-1];
            end
        end
        assign quot = pad_reg[PAD-1];
    end
endmodule

@@ hdl/uvs_cordic_cell.sv @@
// one rotation-mode cordic iteration, registered
module uvs_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  uvs_pkg::cordic_t d_in,
    output uvs_pkg::cordic_t d_out
);
    import uvs_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = signed'({1'b0, atan_q30(IDX)});

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    cordic_t                cell_next;
    cordic_t                cell_reg;

    always_comb
    begin
        dx        = d_in.y >>> IDX;
        dy        = d_in.x >>> IDX;
        cell_next = d_in;
        if (!d_in.z[Z_W-1])
        begin
            cell_next.x = d_in.x - dx;
            cell_next.y = d_in.y + dy;
            cell_next.z = d_in.z - ANGLE;
        end
        else
        begin
            cell_next.x = d_in.x + dx;
            cell_next.y = d_in.y - dy;
            cell_next.z = d_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;
endmodule

@@ hdl/uv_sphere_vertex_generator_unit.sv @@
// top level of the uv sphere vertex generator: grid point in, vertex out
//
// usage
// - a grid point (column, row) is taken at each rising edge with start high and busy low;
//   busy is always low, so one point can be sent in every cycle
// - each vertex comes back in input order, with result_valid high for exactly one cycle; the
//   receiver cannot stall, the transfer happens at the edge that ends that cycle
// - the pipeline is made of the division rows (33 cells for the longitude phase), the cordic
//   rows (one cell per iteration) and six input, mapping, rounding and scaling stages
// - radius, slice count and stack count are written on the cfg channel (cfg_ready is
//   always high); write them only while no vertex is in flight, the divisors are read
//   directly by every cell
// - reset clears the pipeline valid bits and loads radius 1.0, 16 slices and 16 stacks
// - a point outside the grid, or a zero count, gives in_range low and all other fields zero
module uv_sphere_vertex_generator_unit #(
    parameter int MAX_SEGMENTS  = uvs_pkg::SEG_DEFAULT,
    parameter int CORDIC_STAGES = uvs_pkg::CORDIC_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [uvs_pkg::CNT_W-1:0]            column,
    input  logic [uvs_pkg::CNT_W-1:0]            row,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [uvs_pkg::CFG_DAT_W-1:0]        cfg_data,
    output logic                                 result_valid,
    output logic signed [uvs_pkg::POS_W-1:0]     pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]     pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]     pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0]    norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0]    norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0]    norm_z,
    output logic [uvs_pkg::TEX_W-1:0]            tex_u,
    output logic [uvs_pkg::TEX_W-1:0]            tex_v,
    output logic                                 in_range
);
    import uvs_pkg::*;

    // cordic iterations actually used
    localparam int NS      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int DIV_LAT = 33;
    localparam int LAT     = NS + 39;
    // in_range from the input register to the final stage
    localparam int RNG_D   = NS + 37;
    // texcoords from the division output to the final stage
    localparam int TEX_D   = NS + 4;

    // configuration registers
    logic [RAD_W-1:0] radius_reg;
    logic [CNT_W-1:0] slices_reg;
    logic [CNT_W-1:0] stacks_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(256);
            slices_reg <= CNT_W'(16);
            stacks_reg <= CNT_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_SLICES: slices_reg <= cfg_data[CNT_W-1:0];
                CFG_STACKS: stacks_reg <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // counts clipped to the segment limit
    logic [CNT_W-1:0] sl_eff;
    logic [CNT_W-1:0] st_eff;

    always_comb
    begin
        sl_eff = (32'(slices_reg) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : slices_reg;
        st_eff = (32'(stacks_reg) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : stacks_reg;
    end

    // valid pipeline, one bit per stage
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    assign result_valid = vld_reg[LAT-1];

    // input register
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic             rng_reg;
    logic             rng_next;

    assign rng_next = (sl_eff != '0) && (st_eff != '0) && (column <= sl_eff) && (row <= st_eff);

    always_ff @(posedge clk)
    begin
        col_reg <= column;
        row_reg <= row;
        rng_reg <= rng_next;
    end

    // division rows: numerator (index << shift) + count/2, remainder seeded with index/2
    logic [32:0]      theta_q;
    logic [31:0]      phi_q;
    logic [TEX_W-1:0] u_q;
    logic [TEX_W-1:0] v_q;

    uvs_div_chain #(.STEPS(33), .PAD(0)) u_div_theta (
        .clk     (clk),
        .divisor (sl_eff),
        .rem_in  ({1'b0, col_reg[CNT_W-1:1]}),
        .bits_in ({col_reg[0], 24'd0, sl_eff[CNT_W-1:1]}),
        .quot    (theta_q)
    );

    uvs_div_chain #(.STEPS(32), .PAD(DIV_LAT - 32)) u_div_phi (
        .clk     (clk),
        .divisor (st_eff),
        .rem_in  ({1'b0, row_reg[CNT_W-1:1]}),
        .bits_in ({row_reg[0], 23'd0, st_eff[CNT_W-1:1]}),
        .quot    (phi_q)
    );

    uvs_div_chain #(.STEPS(TEX_W), .PAD(DIV_LAT - TEX_W)) u_div_u (
        .clk     (clk),
        .divisor (sl_eff),
        .rem_in  ({1'b0, col_reg[CNT_W-1:1]}),
        .bits_in ({col_reg[0], 7'd0, sl_eff[CNT_W-1:1]}),
        .quot    (u_q)
    );

    uvs_div_chain #(.STEPS(TEX_W), .PAD(DIV_LAT - TEX_W)) u_div_v (
        .clk     (clk),
        .divisor (st_eff),
        .rem_in  ({1'b0, row_reg[CNT_W-1:1]}),
        .bits_in ({row_reg[0], 7'd0, st_eff[CNT_W-1:1]}),
        .quot    (v_q)
    );

    // phase to quadrant and q30 radians
    logic [60:0] theta_rad;
    logic [60:0] phi_rad;
    cordic_t     theta_seed_reg;
    cordic_t     phi_seed_reg;

    always_comb
    begin
        theta_rad = 61'(theta_q[29:0]) * 61'(HALF_PI_Q30) + 61'(1 << 29);
        phi_rad   = 61'(phi_q[29:0]) * 61'(HALF_PI_Q30) + 61'(1 << 29);
    end

    always_ff @(posedge clk)
    begin
        theta_seed_reg.x    <= GAIN_Q30;
        theta_seed_reg.y    <= '0;
        theta_seed_reg.z    <= signed'({2'b00, theta_rad[60:30]});
        theta_seed_reg.quad <= theta_q[31:30];
        phi_seed_reg.x      <= GAIN_Q30;
        phi_seed_reg.y      <= '0;
        phi_seed_reg.z      <= signed'({2'b00, phi_rad[60:30]});
        phi_seed_reg.quad   <= phi_q[31:30];
    end

    // cordic rows, one cell per iteration
    cordic_t theta_w [NS+1];
    cordic_t phi_w   [NS+1];

    assign theta_w[0] = theta_seed_reg;
    assign phi_w[0]   = phi_seed_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        uvs_cordic_cell #(.IDX(i)) u_theta (
            .clk   (clk),
            .d_in  (theta_w[i]),
            .d_out (theta_w[i+1])
        );
        uvs_cordic_cell #(.IDX(i)) u_phi (
            .clk   (clk),
            .d_in  (phi_w[i]),
            .d_out (phi_w[i+1])
        );
    end

    // quadrant mapping
    logic signed [XY_W-1:0] ct_reg;
    logic signed [XY_W-1:0] st_reg;
    logic signed [XY_W-1:0] cp_reg;
    logic signed [XY_W-1:0] sp_reg;

    always_ff @(posedge clk)
    begin
        case (theta_w[NS].quad)
            2'd0:    begin ct_reg <= theta_w[NS].x;  st_reg <= theta_w[NS].y;  end
            2'd1:    begin ct_reg <= -theta_w[NS].y; st_reg <= theta_w[NS].x;  end
            2'd2:    begin ct_reg <= -theta_w[NS].x; st_reg <= -theta_w[NS].y; end
            default: begin ct_reg <= theta_w[NS].y;  st_reg <= -theta_w[NS].x; end
        endcase
        case (phi_w[NS].quad)
            2'd0:    begin cp_reg <= phi_w[NS].x;  sp_reg <= phi_w[NS].y;  end
            2'd1:    begin cp_reg <= -phi_w[NS].y; sp_reg <= phi_w[NS].x;  end
            2'd2:    begin cp_reg <= -phi_w[NS].x; sp_reg <= -phi_w[NS].y; end
            default: begin cp_reg <= phi_w[NS].y;  sp_reg <= -phi_w[NS].x; end
        endcase
    end

    // normal in q30: x and z are sin phi times cos/sin theta, rounded half up, y is cos phi
    logic signed [2*XY_W-1:0] nx_prod;
    logic signed [2*XY_W-1:0] nz_prod;
    logic signed [XY_W-1:0]   n_reg [3];

    always_comb
    begin
        nx_prod = (2*XY_W)'(sp_reg) * (2*XY_W)'(ct_reg) + (2*XY_W)'(1 << 29);
        nz_prod = (2*XY_W)'(sp_reg) * (2*XY_W)'(st_reg) + (2*XY_W)'(1 << 29);
    end

    always_ff @(posedge clk)
    begin
        n_reg[0] <= XY_W'(nx_prod >>> 30);
        n_reg[1] <= cp_reg;
        n_reg[2] <= XY_W'(nz_prod >>> 30);
    end

    // scale by radius, normal to q14
    localparam int PR_W = XY_W + RAD_W + 1;

    logic signed [PR_W-1:0]   praw_reg [3];
    logic signed [NORM_W-1:0] q_reg    [3];
    logic signed [XY_W-1:0]   q_round  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q_round[k] = (n_reg[k] + XY_W'(1 << 15)) >>> 16;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            praw_reg[k] <= PR_W'(n_reg[k]) * PR_W'(signed'({1'b0, radius_reg}));
            if (q_round[k] > XY_W'(16384))
                q_reg[k] <= NORM_W'(16384);
            else if (q_round[k] < -XY_W'(16384))
                q_reg[k] <= -NORM_W'(16384);
            else
                q_reg[k] <= NORM_W'(q_round[k]);
        end
    end

    // sideband delay lines
    logic             rng_dly_reg [RNG_D];
    logic [TEX_W-1:0] u_dly_reg   [TEX_D];
    logic [TEX_W-1:0] v_dly_reg   [TEX_D];

    always_ff @(posedge clk)
    begin
        rng_dly_reg[0] <= rng_reg;
        for (int k = 1; k < RNG_D; k++)
        begin
            rng_dly_reg[k] <= rng_dly_reg[k-1];
        end
        u_dly_reg[0] <= u_q;
        v_dly_reg[0] <= v_q;
        for (int k = 1; k < TEX_D; k++)
        begin
            u_dly_reg[k] <= u_dly_reg[k-1];
            v_dly_reg[k] <= v_dly_reg[k-1];
        end
    end

    // final rounding, clamp and out-of-range zeroing
    logic signed [PR_W-1:0]   p_round [3];
    logic signed [POS_W-1:0]  p_clamp [3];
    logic signed [POS_W-1:0]  pos_reg [3];
    logic signed [NORM_W-1:0] nrm_reg [3];
    logic [TEX_W-1:0]         u_reg;
    logic [TEX_W-1:0]         v_reg;
    logic                     ok_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_round[k] = (praw_reg[k] + PR_W'(1 << 29)) >>> 30;
            if (p_round[k] > PR_W'(65535))
                p_clamp[k] = POS_W'(65535);
            else if (p_round[k] < -PR_W'(65535))
                p_clamp[k] = -POS_W'(65535);
            else
                p_clamp[k] = POS_W'(p_round[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= rng_dly_reg[RNG_D-1];
        u_reg  <= rng_dly_reg[RNG_D-1] ? u_dly_reg[TEX_D-1] : '0;
        v_reg  <= rng_dly_reg[RNG_D-1] ? v_dly_reg[TEX_D-1] : '0;
        for (int k = 0; k < 3; k++)
        begin
            pos_reg[k] <= rng_dly_reg[RNG_D-1] ? p_clamp[k] : '0;
            nrm_reg[k] <= rng_dly_reg[RNG_D-1] ? q_reg[k] : '0;
        end
    end

    assign pos_x    = pos_reg[0];
    assign pos_y    = pos_reg[1];
    assign pos_z    = pos_reg[2];
    assign norm_x   = nrm_reg[0];
    assign norm_y   = nrm_reg[1];
    assign norm_z   = nrm_reg[2];
    assign tex_u    = u_reg;
    assign tex_v    = v_reg;
    assign in_range = ok_reg;
endmodule

@@ tb/sv/tb_uv_sphere_vertex_generator_unit.sv @@
// self-checking testbench of the uv sphere vertex generator: directed grid points, then random phases
module tb_uv_sphere_vertex_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import uvs_pkg::*;

    // pipeline depth at the default stage count, used for the drain at the end
    localparam int N_STAGES    = 16;
    localparam int LATENCY     = N_STAGES + 39;
    localparam int SEG_LIMIT   = 256;
    localparam int RANDOM_ITEMS = 1320;
    localparam int N_PHASES    = 8;

    // unused register index, a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint GAIN     = 64'sh26DD3B6A;
    localparam longint HALF_PI_SCALE = 64'sd1686629713;
    localparam longint POS_LIM  = 65535;
    localparam longint NORM_LIM = 16384;

    // truncated q30 arctangent of 2^-i
    localparam longint ATAN_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    typedef struct {
        logic signed [POS_W-1:0]  px, py, pz;
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic [TEX_W-1:0]         u, v;
        logic                     ok;
    } vertex_t;

    // one directed row: a grid point, and where it is obvious, the vertex it must give
    typedef struct {
        int      col;
        int      rw;
        bit      typed;
        vertex_t want;
    } point_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] row;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic result_valid;
    logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
    logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
    logic [TEX_W-1:0] tex_u, tex_v;
    logic in_range;

    // shadow copy of the configuration registers
    int unsigned radius_q8;
    int unsigned slices;
    int unsigned stacks;

    // vertices still owed by the pipeline, oldest first
    vertex_t pending_vertices[$];
    int      mismatches;
    bit      quiet_stretch;

    uv_sphere_vertex_generator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .column(column), .row(row),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tex_u(tex_u), .tex_v(tex_v), .in_range(in_range)
    );

    always #5 clk = ~clk;

    // floor shift with half-up rounding
    function automatic longint round_q(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // cosine and sine in q30 of a 32-bit turn phase, cordic after quadrant split
    function automatic void turn_sincos(input logic [31:0] ph, output longint c, output longint s);
        longint x, y, z, dx, dy;
        longint unsigned r;
        r = ph[29:0];
        z = longint'((r * longint'(HALF_PI_SCALE) + (64'd1 << 29)) >> 30);
        x = GAIN;
        y = 0;
        for (int i = 0; i < N_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
            end
        end
        case (ph[31:30])
            2'd0:
            begin
                c = x;  s = y;
            end
            2'd1:
            begin
                c = -y; s = x;
            end
            2'd2:
            begin
                c = -x; s = -y;
            end
            default:
            begin
                c = y;  s = -x;
            end
        endcase
    endfunction

    function automatic longint unsigned ratio_round(input longint unsigned num,
                                                    input longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    // vertex of grid point (col, rw) under the current shadow configuration
    function automatic vertex_t sphere_vertex(input int unsigned col, input int unsigned rw);
        vertex_t vx;
        longint unsigned sl, st;
        longint ct, stt, cp, sp;
        longint nrm [3];
        logic [31:0] ph;
        vx = '{default: '0};
        sl = (slices > SEG_LIMIT) ? SEG_LIMIT : slices;
        st = (stacks > SEG_LIMIT) ? SEG_LIMIT : stacks;
        if (sl == 0 || st == 0 || col > sl || rw > st)
            return vx;
        ph = 32'(ratio_round(longint'(col) << 32, sl));
        turn_sincos(ph, ct, stt);
        ph = 32'(ratio_round(longint'(rw) << 31, st));
        turn_sincos(ph, cp, sp);
        nrm[0] = round_q(sp * ct, 30);
        nrm[1] = cp;
        nrm[2] = round_q(sp * stt, 30);
        vx.px = POS_W'(sat(round_q(nrm[0] * longint'(radius_q8), 30), POS_LIM));
        vx.py = POS_W'(sat(round_q(nrm[1] * longint'(radius_q8), 30), POS_LIM));
        vx.pz = POS_W'(sat(round_q(nrm[2] * longint'(radius_q8), 30), POS_LIM));
        vx.nx = NORM_W'(sat(round_q(nrm[0], 16), NORM_LIM));
        vx.ny = NORM_W'(sat(round_q(nrm[1], 16), NORM_LIM));
        vx.nz = NORM_W'(sat(round_q(nrm[2], 16), NORM_LIM));
        vx.u  = TEX_W'(ratio_round(longint'(col) << 15, sl));
        vx.v  = TEX_W'(ratio_round(longint'(rw) << 15, st));
        vx.ok = 1'b1;
        return vx;
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: every strobe is a transfer, compared with the oldest vertex owed
    always @(posedge clk)
    begin
        vertex_t w;
        if (rst_n && result_valid)
        begin
            if (pending_vertices.size() == 0)
            begin
                $error("vertex with no grid point outstanding");
                mismatches++;
            end
            else
            begin
                w = pending_vertices.pop_front();
                check_field("pos_x", w.px, pos_x);
                check_field("pos_y", w.py, pos_y);
                check_field("pos_z", w.pz, pos_z);
                check_field("norm_x", w.nx, norm_x);
                check_field("norm_y", w.ny, norm_y);
                check_field("norm_z", w.nz, norm_z);
                check_field("tex_u", w.u, tex_u);
                check_field("tex_v", w.v, tex_v);
                check_field("in_range", w.ok, in_range);
            end
        end
    end

    // one grid point transfer; start stays high when the next point follows at once
    task automatic send_point(input int unsigned col, input int unsigned rw,
                              input bit typed, input vertex_t typed_vertex);
        start  <= 1'b1;
        column <= col[CNT_W-1:0];
        row    <= rw[CNT_W-1:0];
        @(posedge clk);
        while (busy) @(posedge clk);
        if (typed)
            pending_vertices = {pending_vertices, typed_vertex};
        else
            pending_vertices = {pending_vertices,
                                sphere_vertex(col[CNT_W-1:0], rw[CNT_W-1:0])};
    endtask

    // random idle cycles on the sender side, skipped during the quiet stretch
    task automatic maybe_idle();
        if (!quiet_stretch)
        begin
            while ($urandom_range(0, 99) < 38)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // register write, only once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        start <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS: radius_q8 = data;
            CFG_SLICES: slices = data[CNT_W-1:0];
            CFG_STACKS: stacks = data[CNT_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic configure(input int unsigned rad, input int unsigned sl, input int unsigned st);
        write_reg(CFG_RADIUS, rad[CFG_DAT_W-1:0]);
        write_reg(CFG_SLICES, sl[CFG_DAT_W-1:0]);
        write_reg(CFG_STACKS, st[CFG_DAT_W-1:0]);
    endtask

    // random point: mostly on the grid, corners now and then, the rest any 9-bit value
    task automatic random_point();
        int unsigned sl, st, col, rw, pick;
        vertex_t none;
        none = '{default: '0};
        sl = (slices > SEG_LIMIT) ? SEG_LIMIT : slices;
        st = (stacks > SEG_LIMIT) ? SEG_LIMIT : stacks;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            col = $urandom_range(0, sl);
            rw  = $urandom_range(0, st);
        end
        else if (pick < 85)
        begin
            col = $urandom_range(0, 1) ? sl : 0;
            rw  = $urandom_range(0, 1) ? st : 0;
        end
        else
        begin
            col = $urandom_range(0, 511);
            rw  = $urandom_range(0, 511);
        end
        send_point(col, rw, 1'b0, none);
        maybe_idle();
    endtask

    initial
    begin
        point_row_t directed [$];
        vertex_t zero_v;
        int unsigned rad, sl, st;
        int per_phase;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        column = '0;
        row = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        mismatches = 0;
        quiet_stretch = 1'b0;
        radius_q8 = 256;
        slices = 16;
        stacks = 16;
        zero_v = '{default: '0};

        // reset settings: radius 1.0, 16 slices, 16 stacks
        // off-grid points must give the all-zero vertex with in_range low
        directed = '{
            '{0, 0, 1'b0, zero_v}, '{16, 16, 1'b0, zero_v}, '{16, 0, 1'b0, zero_v},
            '{0, 16, 1'b0, zero_v}, '{8, 8, 1'b0, zero_v}, '{4, 12, 1'b0, zero_v},
            '{12, 4, 1'b0, zero_v}, '{3, 5, 1'b0, zero_v}, '{15, 1, 1'b0, zero_v},
            '{17, 0, 1'b1, zero_v}, '{0, 17, 1'b1, zero_v}, '{256, 256, 1'b1, zero_v},
            '{511, 511, 1'b1, zero_v}, '{511, 0, 1'b1, zero_v}, '{0, 511, 1'b1, zero_v}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, back to back
        foreach (directed[i])
            send_point(directed[i].col, directed[i].rw, directed[i].typed, directed[i].want);
        start <= 1'b0;

        // register extremes: largest radius and finest grid
        configure(65535, 256, 256);
        send_point(0, 0, 1'b0, zero_v);
        send_point(256, 256, 1'b0, zero_v);
        send_point(64, 128, 1'b0, zero_v);
        send_point(192, 77, 1'b0, zero_v);
        send_point(257, 0, 1'b1, zero_v);
        // coarsest grid, zero radius
        configure(0, 1, 1);
        send_point(1, 1, 1'b0, zero_v);
        send_point(0, 1, 1'b0, zero_v);
        send_point(2, 0, 1'b1, zero_v);
        // zero count: everything is off the grid
        configure(256, 0, 16);
        send_point(0, 0, 1'b1, zero_v);
        send_point(0, 8, 1'b1, zero_v);
        // count above the segment limit is taken as the limit
        configure(384, 300, 511);
        send_point(256, 256, 1'b0, zero_v);
        send_point(257, 100, 1'b1, zero_v);
        // unknown index: this write must not disturb the radius
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_point(37, 90, 1'b0, zero_v);
        start <= 1'b0;

        // random phases, each with its own grid and radius
        per_phase = RANDOM_ITEMS / N_PHASES;
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    rad = 256;   sl = 16;  st = 16;
                end
                1:
                begin
                    rad = 65535; sl = 256; st = 256;
                end
                2:
                begin
                    rad = 1;     sl = 1;   st = 2;
                end
                3:
                begin
                    rad = $urandom_range(0, 65535); sl = $urandom_range(0, 65535);
                    st = $urandom_range(0, 65535);
                end
                default:
                begin
                    rad = $urandom_range(0, 65535); sl = $urandom_range(1, 256);
                    st = $urandom_range(1, 256);
                end
            endcase
            configure(rad, sl, st);
            for (int k = 0; k < per_phase; k++)
            begin
                // one phase runs without any sender gaps
                quiet_stretch = (p == 5);
                random_point();
            end
            start <= 1'b0;
        end
        start <= 1'b0;

        // drain, then a pipeline's worth of extra cycles to catch strays
        while (pending_vertices.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/uvs_pkg.sv
hdl/uvs_div_cell.sv
hdl/uvs_div_chain.sv
hdl/uvs_cordic_cell.sv
hdl/uv_sphere_vertex_generator_unit.sv
tb/sv/tb_uv_sphere_vertex_generator_unit.sv
